FILE: hdl/spe_pkg.sv
// spe_pkg: shared types, constants and helpers for the signed permutation enumerator
// no dependencies; imported by spe_step and signed_permutation_enumerator
package spe_pkg;

    localparam int MAX_DIM   = 8;
    localparam int POS_W     = 3;
    localparam int DIM_W     = 4;
    localparam int POSITIONS_W = MAX_DIM * POS_W;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    typedef logic [MAX_DIM-1:0][POS_W-1:0] order_t;
    typedef logic [MAX_DIM-1:0]            signs_t;
    typedef logic [DIM_W-1:0]              dim_t;

    typedef struct packed {
        logic [POSITIONS_W-1:0] positions;
        signs_t                 sign_mask;
        logic                   last_symmetry;
    } result_t;

    function automatic order_t identity_order();
        order_t o;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            o[i] = POS_W'(i);
        end
        return o;
    endfunction

    function automatic dim_t clamp_dim(dim_t d);
        dim_t n;
        n = d;
        if (d == '0)
        begin
            n = dim_t'(1);
        end
        else if (d > dim_t'(MAX_DIM))
        begin
            n = dim_t'(MAX_DIM);
        end
        return n;
    endfunction

    function automatic signs_t active_mask(dim_t n);
        signs_t m;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            m[i] = (dim_t'(i) < n);
        end
        return m;
    endfunction

endpackage

FILE: hdl/spe_step.sv
// spe_step: combinational emit-and-advance for one request word
// depends on spe_pkg (order_t, result_t, helpers)
module spe_step (
    input  spe_pkg::order_t  order_cur,
    input  spe_pkg::signs_t  sign_cur,
    input  logic             restart,
    input  spe_pkg::dim_t    dim_n,
    output spe_pkg::result_t result,
    output spe_pkg::order_t  order_next,
    output spe_pkg::signs_t  sign_next
);
    import spe_pkg::*;

    order_t           a;
    order_t           b;
    order_t           perm;
    signs_t           mask;
    signs_t           signs;
    logic             carry;
    logic             found;
    logic [POS_W-1:0] pivot;
    logic [POS_W-1:0] j_idx;
    logic [POS_W-1:0] a_piv;
    logic [DIM_W-1:0] src;

    always_comb
    begin
        a     = restart ? identity_order() : order_cur;
        mask  = active_mask(dim_n);
        signs = restart ? '0 : (sign_cur & mask);
        carry = (signs == mask);

        // pivot: highest i with a[i] < a[i+1] inside the active range
        found = 1'b0;
        pivot = '0;
        for (int i = 0; i < MAX_DIM - 1; i++)
        begin
            if ((dim_t'(i + 1) < dim_n) && (a[i] < a[i + 1]))
            begin
                found = 1'b1;
                pivot = POS_W'(i);
            end
        end
        a_piv = a[pivot];

        // rightmost entry above the pivot value
        j_idx = pivot + POS_W'(1);
        for (int i = 0; i < MAX_DIM; i++)
        begin
            if ((POS_W'(i) > pivot) && (dim_t'(i) < dim_n) && (a[i] > a_piv))
            begin
                j_idx = POS_W'(i);
            end
        end

        b        = a;
        b[pivot] = a[j_idx];
        b[j_idx] = a_piv;

        // reverse the suffix after the pivot
        perm = b;
        src  = '0;
        for (int k = 0; k < MAX_DIM; k++)
        begin
            src = dim_t'(pivot) + dim_n - dim_t'(k);
            if ((POS_W'(k) > pivot) && (dim_t'(k) < dim_n))
            begin
                perm[k] = b[src[POS_W-1:0]];
            end
        end
        if (!found)
        begin
            perm = identity_order();
        end

        for (int i = 0; i < MAX_DIM; i++)
        begin
            result.positions[i*POS_W +: POS_W] = mask[i] ? a[i] : '0;
        end
        result.sign_mask     = signs;
        result.last_symmetry = carry && !found;

        if (carry)
        begin
            sign_next  = '0;
            order_next = perm;
        end
        else
        begin
            sign_next  = signs + signs_t'(1);
            order_next = a;
        end
    end

endmodule

FILE: hdl/signed_permutation_enumerator.sv
// signed_permutation_enumerator: emits one hypercube symmetry per request word
// the result word is registered and valid in the cycle after the request word is accepted
// one word per cycle while the output register can be drained; the next-permutation logic is combinational
// s_axis_tready stays high while the output register is empty or being drained
// reset (rst_n low, async): identity order, zero sign count, dimension 3, no output
// depends on spe_pkg and spe_step
module signed_permutation_enumerator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,    // dimension
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] positions, [31:24] sign_mask
    output logic        m_axis_tlast    // last_symmetry
);
    import spe_pkg::*;

    dim_t    dim_reg;
    order_t  order_reg;
    order_t  order_next;
    signs_t  sign_reg;
    signs_t  sign_next;
    result_t step_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_fire;
    dim_t    dim_n;

    assign dim_n         = clamp_dim(dim_reg);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    spe_step u_step (
        .order_cur  (order_reg),
        .sign_cur   (sign_reg),
        .restart    (s_axis_tdata[0]),
        .dim_n      (dim_n),
        .result     (step_result),
        .order_next (order_next),
        .sign_next  (sign_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= DIM_RESET;
            order_reg     <= identity_order();
            sign_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dim_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                order_reg <= order_next;
                sign_reg  <= sign_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.sign_mask, out_reg.positions};
    assign m_axis_tlast  = out_reg.last_symmetry;

`ifndef SYNTH
    // an accepted request always yields a pending word next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request produced no output word");

    // restart emits a zero sign mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tdata[0]) |=> (out_reg.sign_mask == '0))
        else $error("restart did not clear the sign mask");

    // last symmetry carries all active sign bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_symmetry)
            |-> (out_reg.sign_mask == active_mask(dim_n)))
        else $error("last symmetry without full sign mask");

    // sign count never holds bits outside the active range after a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_wr_en) |=> ((sign_reg & ~active_mask(dim_n)) == '0))
        else $error("sign count left inactive bits set");
`endif

endmodule
